[rtl/int_to_grouped_decimal_macros.svh]
// assertion macros for the grouped decimal formatter
// used by the top level only; expects clk and rst in scope
`ifndef INT_TO_GROUPED_DECIMAL_MACROS_SVH
`define INT_TO_GROUPED_DECIMAL_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define IGD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("igd assertion failed");

// next-cycle implication
`define IGD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("igd assertion failed");

`else

`define IGD_ASSERT_IMP(label, ante, cons)
`define IGD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[rtl/igd_pkg.sv]
`timescale 1ns / 1ps
// shared types, character codes and helpers for the grouped decimal formatter
// no dependencies
package igd_pkg;

  localparam int MAX_WIDTH_DEFAULT = 64;
  localparam int BIN_W             = 64;
  localparam int DIGITS            = 20;
  localparam int GROUP_LEN         = 3;
  localparam int MAX_SEPS          = 6;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef enum logic [1:0] {
    CH_SPACE = 2'd0,
    CH_SIGN  = 2'd1,
    CH_DIGIT = 2'd2
  } ch_sel_t;

  typedef struct packed {
    logic    load;
    logic    conv_step;
    logic    measure;
    logic    emit;
    ch_sel_t sel;
  } igd_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic pad_zero;
    logic neg;
    logic last_digit;
    logic sep_due;
    logic out_free;
  } igd_stat_t;

  // number of separators for a run of nd digits, i.e. (nd - 1) / 3
  function automatic logic [2:0] sep_count(input logic [4:0] nd);
    logic [2:0] cnt;
    cnt = 3'd0;
    for (int k = 1; k <= MAX_SEPS; k++) begin
      if (nd > 5'(GROUP_LEN * k)) cnt = cnt + 3'd1;
    end
    return cnt;
  endfunction

endpackage

[rtl/igd_ctrl.sv]
`timescale 1ns / 1ps
// sequencer for the grouped decimal formatter
// depends on igd_pkg; drives commands into igd_datapath
module igd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  igd_pkg::igd_stat_t stat,
  output igd_pkg::igd_cmd_t  cmd,
  output logic              idle
);
  import igd_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CONV  = 7'b0000010,
    S_MEAS  = 7'b0000100,
    S_PAD   = 7'b0001000,
    S_SIGN  = 7'b0010000,
    S_DIGIT = 7'b0100000,
    S_SEP   = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.sel       = CH_SPACE;
    idle          = 1'b0;
    case (state)
      S_IDLE: begin
        idle = 1'b1;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CONV;
        end
      end
      S_CONV: begin
        cmd.conv_step = 1'b1;
        if (stat.conv_done) state_next = S_MEAS;
      end
      S_MEAS: begin
        cmd.measure = 1'b1;
        state_next  = S_PAD;
      end
      S_PAD: begin
        if (stat.pad_zero) begin
          state_next = stat.neg ? S_SIGN : S_DIGIT;
        end else if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = CH_SPACE;
        end
      end
      S_SIGN: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = CH_SIGN;
          state_next = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = CH_DIGIT;
          if (stat.last_digit) begin
            state_next = S_IDLE;
          end else if (stat.sep_due) begin
            state_next = S_SEP;
          end
        end
      end
      S_SEP: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = CH_SPACE;
          state_next = S_DIGIT;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/igd_datapath.sv]
`timescale 1ns / 1ps
// datapath: shift-and-add-3 converter, length measure, character counters, output register
// depends on igd_pkg; commanded by igd_ctrl
module igd_datapath #(
  parameter int MAX_WIDTH = igd_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  igd_pkg::igd_cmd_t  cmd,
  output igd_pkg::igd_stat_t stat,
  input  logic [63:0]        value,
  input  logic [7:0]         min_width,
  output logic [7:0]         out_char,
  output logic               last_char,
  output logic               out_valid,
  input  logic               out_ready
);
  import igd_pkg::*;

  localparam int PadW = $clog2(MAX_WIDTH + 1);
  localparam int CntW = $clog2(BIN_W);

  logic [BIN_W-1:0] mag;
  logic [3:0]       bcd [DIGITS];
  logic [3:0]       adj [DIGITS];
  logic [CntW-1:0]  bit_cnt;
  logic             neg;
  logic [7:0]       width;
  logic [PadW-1:0]  pad;
  logic [4:0]       pos;
  logic [1:0]       grp;

  logic [4:0]       nd_c;
  logic [2:0]       sc_c;
  logic [4:0]       len_c;
  logic [7:0]       pad_c;
  logic [1:0]       grp_c;
  logic [7:0]       char_c;

  // add 3 to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      adj[i] = (bcd[i] >= 4'd5) ? bcd[i] + 4'd3 : bcd[i];
    end
  end

  // digit count, text length and padding once the conversion is done
  always_comb begin
    nd_c = 5'd1;
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[i] != 4'd0) nd_c = 5'(i + 1);
    end
    sc_c  = sep_count(nd_c);
    len_c = 5'(neg) + nd_c + 5'(sc_c);
    grp_c = 2'(nd_c - 5'd1 - 5'(sc_c) * 5'(GROUP_LEN));
    if (width != 8'd0 && width > 8'(len_c) && width <= 8'(MAX_WIDTH)) begin
      pad_c = width - 8'(len_c);
    end else begin
      pad_c = 8'd0;
    end
  end

  always_comb begin
    case (cmd.sel)
      CH_SPACE: char_c = CHAR_SPACE;
      CH_SIGN:  char_c = CHAR_MINUS;
      CH_DIGIT: char_c = CHAR_ZERO | {4'd0, bcd[pos]};
      default:  char_c = CHAR_SPACE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg     <= value[63];
      mag     <= value[63] ? (~value + 64'd1) : value;
      width   <= min_width;
      bit_cnt <= '0;
      for (int i = 0; i < DIGITS; i++) bcd[i] <= 4'd0;
    end else if (cmd.conv_step) begin
      mag     <= {mag[BIN_W-2:0], 1'b0};
      bit_cnt <= bit_cnt + 1'b1;
      bcd[0]  <= {adj[0][2:0], mag[BIN_W-1]};
      for (int i = 1; i < DIGITS; i++) bcd[i] <= {adj[i][2:0], adj[i-1][3]};
    end
    if (cmd.measure) begin
      pad <= PadW'(pad_c);
      pos <= nd_c - 5'd1;
      grp <= grp_c;
    end else if (cmd.emit) begin
      case (cmd.sel)
        CH_SPACE: begin
          if (pad != '0) pad <= pad - 1'b1;
        end
        CH_DIGIT: begin
          pos <= pos - 5'd1;
          grp <= (grp == 2'd0) ? 2'(GROUP_LEN - 1) : grp - 2'd1;
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_char  <= char_c;
      last_char <= (cmd.sel == CH_DIGIT) && (pos == 5'd0);
    end
  end

  assign stat.conv_done  = (bit_cnt == CntW'(BIN_W - 1));
  assign stat.pad_zero   = (pad == '0);
  assign stat.neg        = neg;
  assign stat.last_digit = (pos == 5'd0);
  assign stat.sep_due    = (grp == 2'd0);
  assign stat.out_free   = !out_valid || out_ready;

endmodule

[rtl/int_to_grouped_decimal.sv]
`timescale 1ns / 1ps
// top level of the grouped decimal formatter
// depends on igd_pkg, igd_ctrl, igd_datapath and int_to_grouped_decimal_macros.svh

// Formats a signed 64-bit value as decimal ASCII with a leading '-' for negatives and a
// space between groups of three digits, left-padded with spaces to min_width (no padding
// when min_width is 0, not above the text length, or above MAX_WIDTH). Characters leave one
// per handshake on the m_ side, most significant first, with tlast on the final one. One
// request is handled at a time: after acceptance the shift-and-add-3 converter takes one
// input bit per cycle, the text is then measured, and characters are sent one per cycle
// while the output side does not stall, apart from the step that leaves the padding phase.
// s_tready is high only between requests; the last character may still wait in the output
// register meanwhile.
module int_to_grouped_decimal #(
  parameter int MAX_WIDTH = igd_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // [63:0] value, [71:64] min_width
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_char
  output logic        m_tlast    // last_char
);
  import igd_pkg::*;

  igd_cmd_t  cmd;
  igd_stat_t stat;
  logic      idle;
  logic      is_digit;

  assign s_tready = idle;
  assign is_digit = (m_tdata >= CHAR_ZERO) && (m_tdata <= CHAR_NINE);

  igd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (s_tvalid),
    .stat  (stat),
    .cmd   (cmd),
    .idle  (idle)
  );

  igd_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .value     (s_tdata[63:0]),
    .min_width (s_tdata[71:64]),
    .out_char  (m_tdata),
    .last_char (m_tlast),
    .out_valid (m_tvalid),
    .out_ready (m_tready)
  );

`include "int_to_grouped_decimal_macros.svh"

  // once a request is taken the block stays busy through the conversion
  `IGD_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

  // the final character is always a digit
  `IGD_ASSERT_IMP(a_last_is_digit, m_tvalid && m_tlast, is_digit)

  // only digits, the minus sign and spaces ever leave the block
  `IGD_ASSERT_IMP(a_char_set, m_tvalid, is_digit || m_tdata == CHAR_SPACE || m_tdata == CHAR_MINUS)

endmodule
